@@ rtl/ctf_pkg.sv @@
// Shared types and result codes for the CSV field tokenizer.
// No dependencies; every other file of the block imports this package.
package ctf_pkg;

  // Result codes carried in the output tuser field.
  localparam logic [1:0] KindData    = 2'd0;
  localparam logic [1:0] KindElemEnd = 2'd1;
  localparam logic [1:0] KindRowEnd  = 2'd2;
  localparam logic [1:0] KindDiscard = 2'd3;

  // One input byte causes at most this many results.
  localparam int unsigned MaxResults = 3;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } ctf_res_t;

  // All results caused by one input byte; cnt is 1 to MaxResults.
  typedef struct packed {
    logic [1:0]                cnt;
    ctf_res_t [MaxResults-1:0] res;
  } ctf_bundle_t;

endpackage

@@ rtl/csv_field_tokenizer_core.sv @@
// CSV field tokenizer: takes one text byte per transfer and emits element data, element
// end, row end and row discard results, one result per output transfer. The input
// side takes a byte every cycle while the bundle queue has room; each byte that has
// results turns into one bundle of one to three results, and the output register
// sends one result per cycle unless m_axis_tready stalls it, so a byte with N results
// makes N output transfers; bytes with no results send nothing downstream. A queue
// of QueueDepth bundles absorbs bursts of multi-result bytes; sustained input is one byte
// per cycle if results average at most one per byte and the output is unstalled. The
// allow_comments register is for the user to write via cfg_we_i/cfg_wdata_i while idle;
// the block does not enforce this. Depends on ctf_pkg, ctf_front, ctf_queue and ctf_back.
module csv_field_tokenizer_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: allow_comments.
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // Text stream in.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // is_last
  // Result stream out.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [1:0] m_axis_tuser,   // [1:0] result_kind
  output logic       m_axis_tlast    // last_of_run
);
  import ctf_pkg::*;

  logic        allow_comments_q;
  logic        push, full, pop, empty;
  ctf_bundle_t push_bundle, head_bundle;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_comments_q <= 1'b0;
    end else if (cfg_we_i) begin
      allow_comments_q <= cfg_wdata_i;
    end
  end

  ctf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .allow_comments_i (allow_comments_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .text_byte_i      (s_axis_tdata),
    .is_last_i        (s_axis_tlast),
    .queue_full_i     (full),
    .push_o           (push),
    .bundle_o         (push_bundle)
  );

  ctf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_bundle),
    .empty_o     (empty)
  );

  ctf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_bundle),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_kind_o (m_axis_tuser),
    .data_byte_o   (m_axis_tdata),
    .last_of_run_o (m_axis_tlast)
  );

endmodule

@@ rtl/ctf_front.sv @@
// Front end of the CSV field tokenizer: accepts bytes and classifies them.
// Depends on ctf_pkg; produces one result bundle per byte that has results.
module ctf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 allow_comments_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           text_byte_i,
  input  logic                 is_last_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output ctf_pkg::ctf_bundle_t bundle_o
);
  import ctf_pkg::*;

  // Characters that steer the tokenizer.
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;

  // Lookahead hold codes.
  localparam logic [1:0] HoldNone   = 2'd0;
  localparam logic [1:0] HoldBslash = 2'd1;
  localparam logic [1:0] HoldSlash  = 2'd2;

  logic       quoted_q, quoted_d;
  logic [1:0] hold_q, hold_d;
  logic       skip_q, skip_d;
  logic       content_q, content_d;

  logic                      accept;
  logic                      consumed;
  logic [1:0]                cnt;
  ctf_res_t [MaxResults-1:0] res;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Per-byte decision: state update and the list of results it causes.
  always_comb begin
    quoted_d  = quoted_q;
    hold_d    = hold_q;
    skip_d    = skip_q;
    content_d = content_q;
    consumed  = 1'b0;
    cnt       = 2'd0;
    res       = '0;

    // Resolve a held lookahead byte, or swallow bytes of a skipped row.
    if (skip_q) begin
      consumed = 1'b1;
    end else if (hold_q == HoldBslash) begin
      hold_d    = HoldNone;
      res[cnt]  = '{kind: KindData, data: (text_byte_i == ChQuote) ? ChQuote : ChBslash};
      cnt       = cnt + 2'd1;
      content_d = 1'b1;
      consumed  = (text_byte_i == ChQuote);
    end else if (hold_q == HoldSlash) begin
      hold_d = HoldNone;
      if (text_byte_i == ChSlash) begin
        if (content_d) begin
          res[cnt] = '{kind: KindDiscard, data: 8'h00};
          cnt      = cnt + 2'd1;
        end
        skip_d    = 1'b1;
        content_d = 1'b0;
        consumed  = 1'b1;
      end else begin
        res[cnt]  = '{kind: KindData, data: ChSlash};
        cnt       = cnt + 2'd1;
        content_d = 1'b1;
      end
    end else if (hold_q != HoldNone) begin
      hold_d = HoldNone;
    end

    // The byte's own meaning.
    if (!consumed && text_byte_i != ChLf) begin
      if (text_byte_i == ChComma && !quoted_d) begin
        res[cnt]  = '{kind: KindElemEnd, data: 8'h00};
        cnt       = cnt + 2'd1;
        content_d = 1'b1;
      end else if (text_byte_i == ChQuote) begin
        quoted_d = !quoted_d;
      end else if (text_byte_i == ChBslash && quoted_d) begin
        if (is_last_i) begin
          res[cnt]  = '{kind: KindData, data: text_byte_i};
          cnt       = cnt + 2'd1;
          content_d = 1'b1;
        end else begin
          hold_d = HoldBslash;
        end
      end else if (!quoted_d && (text_byte_i == ChCr || text_byte_i == ChTab)) begin
        // Carriage returns and tabs outside strings are dropped.
      end else if (!quoted_d && allow_comments_i && text_byte_i == ChHash) begin
        if (content_d) begin
          res[cnt] = '{kind: KindDiscard, data: 8'h00};
          cnt      = cnt + 2'd1;
        end
        skip_d    = 1'b1;
        hold_d    = HoldNone;
        content_d = 1'b0;
      end else if (!quoted_d && allow_comments_i && text_byte_i == ChSlash) begin
        if (is_last_i) begin
          res[cnt]  = '{kind: KindData, data: text_byte_i};
          cnt       = cnt + 2'd1;
          content_d = 1'b1;
        end else begin
          hold_d = HoldSlash;
        end
      end else begin
        res[cnt]  = '{kind: KindData, data: text_byte_i};
        cnt       = cnt + 2'd1;
        content_d = 1'b1;
      end
    end

    // Row end on newline or on the final byte, if the row has content and is not skipped.
    if (text_byte_i == ChLf || is_last_i) begin
      if (!skip_d && content_d) begin
        res[cnt] = '{kind: KindRowEnd, data: 8'h00};
        cnt      = cnt + 2'd1;
      end
      quoted_d  = 1'b0;
      hold_d    = HoldNone;
      skip_d    = 1'b0;
      content_d = 1'b0;
    end
  end

  assign push_o       = accept && (cnt != 2'd0);
  assign bundle_o.cnt = cnt;
  assign bundle_o.res = res;

  // Tokenizer state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      hold_q    <= HoldNone;
      skip_q    <= 1'b0;
      content_q <= 1'b0;
    end else if (accept) begin
      quoted_q  <= quoted_d;
      hold_q    <= hold_d;
      skip_q    <= skip_d;
      content_q <= content_d;
    end
  end

endmodule

@@ rtl/ctf_queue.sv @@
// Short bundle queue between the front and back ends of the tokenizer.
// Depends on ctf_pkg for the bundle type.
module ctf_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ctf_pkg::ctf_bundle_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output ctf_pkg::ctf_bundle_t pop_data_o,
  output logic                 empty_o
);
  import ctf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ctf_bundle_t     slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntFull);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slots_q[rd_ptr_q];

  // Storage needs no reset; the count says which slots hold data.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/ctf_back.sv @@
// Back end of the tokenizer: unpacks bundles into single result transfers.
// Depends on ctf_pkg; drives the output register of the result stream.
module ctf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  ctf_pkg::ctf_bundle_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           result_kind_o,
  output logic [7:0]           data_byte_o,
  output logic                 last_of_run_o
);
  import ctf_pkg::*;

  ctf_bundle_t cur_q;
  logic        cur_vld_q;
  logic [1:0]  idx_q;
  logic        out_vld_q;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_data_q;
  logic        out_last_q;

  logic slot_free, send, last_res, take;

  assign slot_free = !out_vld_q || out_ready_i;
  assign send      = cur_vld_q && slot_free;
  assign last_res  = (idx_q == (cur_q.cnt - 2'd1));
  assign take      = !cur_vld_q || (send && last_res);
  assign pop_o     = take && !empty_i;

  // Control: current bundle, result index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        cur_vld_q <= !empty_i;
        idx_q     <= 2'd0;
      end else if (send) begin
        idx_q <= idx_q + 2'd1;
      end
      if (send) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (send) begin
      out_kind_q <= cur_q.res[idx_q].kind;
      out_data_q <= cur_q.res[idx_q].data;
      out_last_q <= last_res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_kind_o = out_kind_q;
  assign data_byte_o   = out_data_q;
  assign last_of_run_o = out_last_q;

endmodule
